@@ rtl/plgc_pkg.sv @@
`timescale 1ns / 1ps
// Package for the piecewise-linear gain curve: field widths, codes, controller states
// and the command and status structs between controller and datapath.
// Depends on nothing; every other file of the block imports it.
package plgc_pkg;

	// Fixed point format of positions and gains: unsigned, 1.0 is 1 << FRAC_BITS.
	localparam int FRAC_BITS      = 16;
	localparam int VAL_W          = FRAC_BITS + 1;
	localparam int PROD_W         = 2 * VAL_W;
	localparam int IDX_W          = 4;
	localparam int CNT_W          = 5;
	localparam int MAX_POINTS_DEF = 16;
	localparam int STEP_W         = $clog2(VAL_W);

	typedef logic [VAL_W-1:0] val_t;

	localparam val_t ONE_FX = val_t'(1) << FRAC_BITS;

	// Request kinds carried in req_type.
	localparam logic REQ_LOAD  = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_FIRST,
		ST_LAST,
		ST_SCAN,
		ST_MUL,
		ST_DIV,
		ST_LERP,
		ST_EMIT
	} ctl_state_t;

	// Source of the result register.
	typedef enum logic [1:0] {
		SEL_POS,
		SEL_RD_Y,
		SEL_B_Y,
		SEL_LERP
	} res_sel_t;

	typedef struct packed {
		logic     mem_wr;
		logic     t_ld;
		logic     a_ld;
		logic     b_ld;
		logic     mul_ld;
		logic     div_step;
		logic     res_ld;
		res_sel_t res_sel;
		logic     out_ld;
	} dp_cmd_t;

	typedef struct packed {
		logic t_le_rdx;
		logic t_ge_rdx;
		logic hit;
		logic span_zero;
	} dp_status_t;

	// Clamp a coordinate to 0..1.0.
	function automatic val_t sat_one(input val_t v);
		return (v > ONE_FX) ? ONE_FX : v;
	endfunction

endpackage

@@ rtl/plgc_ifs.sv @@
`timescale 1ns / 1ps
// Channel interfaces of the gain curve: request, response and configuration write.
// Depends on plgc_pkg for the field widths.
interface plgc_req_if import plgc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic             req_type;
	logic [IDX_W-1:0] point_index;
	val_t             point_x;
	val_t             point_y;
	val_t             position;

	modport source (output valid, req_type, point_index, point_x, point_y, position,
		input ready);
	modport sink (input valid, req_type, point_index, point_x, point_y, position,
		output ready);
endinterface

interface plgc_rsp_if import plgc_pkg::*; ;
	logic valid;
	logic ready;
	val_t gain;

	modport source (output valid, gain, input ready);
	modport sink (input valid, gain, output ready);
endinterface

interface plgc_cfg_if import plgc_pkg::*; ;
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] point_count;

	modport source (output valid, point_count, input ready);
	modport sink (input valid, point_count, output ready);
endinterface

@@ rtl/plgc_dp.sv @@
`timescale 1ns / 1ps
// Datapath of the gain curve: breakpoint memory, segment registers, multiplier,
// restoring divider and result/output registers. Driven by plgc_ctrl; uses plgc_pkg.
module plgc_dp import plgc_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  dp_cmd_t                       cmd,
	input  logic [$clog2(MAX_POINTS)-1:0] rd_addr,
	input  logic [IDX_W-1:0]              point_index,
	input  val_t                          point_x,
	input  val_t                          point_y,
	input  val_t                          position,
	output dp_status_t                    status,
	output val_t                          gain
);

	localparam int AW = $clog2(MAX_POINTS);

	val_t mem_x [MAX_POINTS];
	val_t mem_y [MAX_POINTS];
	val_t rd_x_q, rd_y_q;
	val_t t_q, a_x_q, a_y_q, b_x_q, b_y_q;
	val_t span_q, rem_q, quo_q;
	logic desc_q;
	val_t res_q, gain_q;

	logic              wr_ok;
	val_t              diff, off;
	logic [PROD_W-1:0] prod;
	logic [VAL_W:0]    trial_num;
	logic              trial_ge;
	val_t              lerp_val;

	assign wr_ok = int'(point_index) < MAX_POINTS;

	// Breakpoint memory: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.mem_wr && wr_ok) begin
			mem_x[AW'(point_index)] <= sat_one(point_x);
			mem_y[AW'(point_index)] <= sat_one(point_y);
		end
		rd_x_q <= mem_x[rd_addr];
		rd_y_q <= mem_y[rd_addr];
	end

	// Segment arithmetic: offsets into the segment and the product for the divider.
	always_comb begin
		diff = (b_y_q < a_y_q) ? (a_y_q - b_y_q) : (b_y_q - a_y_q);
		off  = t_q - a_x_q;
		prod = PROD_W'(diff) * PROD_W'(off);
	end

	// One restoring division step: shift in the next dividend bit and try to subtract.
	always_comb begin
		trial_num = {rem_q, quo_q[VAL_W-1]};
		trial_ge  = trial_num >= {1'b0, span_q};
	end

	assign lerp_val = desc_q ? (a_y_q - quo_q) : (a_y_q + quo_q);

	always_ff @(posedge clk) begin
		if (cmd.t_ld) begin
			t_q <= sat_one(position);
		end
		if (cmd.a_ld) begin
			a_x_q <= rd_x_q;
			a_y_q <= rd_y_q;
		end
		if (cmd.b_ld) begin
			b_x_q <= rd_x_q;
			b_y_q <= rd_y_q;
		end
		// The high half of the product is below the span, so it seeds the remainder.
		if (cmd.mul_ld) begin
			desc_q <= b_y_q < a_y_q;
			span_q <= b_x_q - a_x_q;
			rem_q  <= prod[PROD_W-1:VAL_W];
			quo_q  <= prod[VAL_W-1:0];
		end else if (cmd.div_step) begin
			if (trial_ge) begin
				rem_q <= VAL_W'(trial_num - {1'b0, span_q});
				quo_q <= {quo_q[VAL_W-2:0], 1'b1};
			end else begin
				rem_q <= trial_num[VAL_W-1:0];
				quo_q <= {quo_q[VAL_W-2:0], 1'b0};
			end
		end
		if (cmd.res_ld) begin
			case (cmd.res_sel)
				SEL_POS:  res_q <= sat_one(position);
				SEL_RD_Y: res_q <= rd_y_q;
				SEL_B_Y:  res_q <= b_y_q;
				SEL_LERP: res_q <= lerp_val;
				default:  res_q <= rd_y_q;
			endcase
		end
		if (cmd.out_ld) begin
			gain_q <= res_q;
		end
	end

	// Comparisons the controller steers by.
	always_comb begin
		status.t_le_rdx  = t_q <= rd_x_q;
		status.t_ge_rdx  = t_q >= rd_x_q;
		status.hit       = (a_x_q <= t_q) && (t_q <= rd_x_q);
		status.span_zero = b_x_q == a_x_q;
	end

	assign gain = gain_q;

endmodule

@@ rtl/plgc_ctrl.sv @@
`timescale 1ns / 1ps
// Controller of the gain curve: point count register, sequencing state machine,
// memory read address, divider step count and output valid. Uses plgc_pkg.
module plgc_ctrl import plgc_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic [CNT_W-1:0]              cfg_count,
	input  logic                          in_valid,
	input  logic                          in_type,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	input  dp_status_t                    status,
	output dp_cmd_t                       cmd,
	output logic [$clog2(MAX_POINTS)-1:0] rd_addr
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);

	ctl_state_t        state_q, state_d;
	logic [CNT_W-1:0]  count_q;
	logic [AW-1:0]     idx_q, idx_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              out_valid_q;

	logic [NW-1:0] n_pts;
	logic [AW-1:0] last_addr;
	logic          out_free;

	// Effective point count, limited to the table depth.
	always_comb begin
		if (int'(count_q) > MAX_POINTS) begin
			n_pts = NW'(MAX_POINTS);
		end else begin
			n_pts = NW'(count_q);
		end
		last_addr = AW'(n_pts - NW'(1));
	end

	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			step_q  <= step_d;
			if (cfg_valid) begin
				count_q <= cfg_count;
			end
			if (cmd.out_ld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and commands.
	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		step_d   = step_q;
		rd_addr  = idx_q;
		in_ready = 1'b0;
		cmd      = '0;
		cmd.res_sel = SEL_RD_Y;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				rd_addr  = '0;
				if (in_valid) begin
					if (in_type == REQ_LOAD) begin
						cmd.mem_wr = 1'b1;
					end else if (n_pts == '0) begin
						cmd.res_ld  = 1'b1;
						cmd.res_sel = SEL_POS;
						state_d     = ST_EMIT;
					end else begin
						cmd.t_ld = 1'b1;
						state_d  = ST_FIRST;
					end
				end
			end
			// Entry 0 is on the read port.
			ST_FIRST: begin
				if (status.t_le_rdx) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.a_ld = 1'b1;
					rd_addr  = last_addr;
					state_d  = ST_LAST;
				end
			end
			// The last valid entry is on the read port.
			ST_LAST: begin
				if (status.t_ge_rdx) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					rd_addr = AW'(1);
					idx_d   = AW'(1);
					state_d = ST_SCAN;
				end
			end
			// Entry idx is on the read port, entry idx-1 sits in the A registers.
			ST_SCAN: begin
				if (status.hit) begin
					cmd.b_ld = 1'b1;
					state_d  = ST_MUL;
				end else if (idx_q == last_addr) begin
					cmd.res_ld = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					cmd.a_ld = 1'b1;
					idx_d    = idx_q + AW'(1);
					rd_addr  = idx_q + AW'(1);
				end
			end
			ST_MUL: begin
				if (status.span_zero) begin
					cmd.res_ld  = 1'b1;
					cmd.res_sel = SEL_B_Y;
					state_d     = ST_EMIT;
				end else begin
					cmd.mul_ld = 1'b1;
					step_d     = '0;
					state_d    = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + STEP_W'(1);
				if (step_q == STEP_W'(VAL_W - 1)) begin
					state_d = ST_LERP;
				end
			end
			ST_LERP: begin
				cmd.res_ld  = 1'b1;
				cmd.res_sel = SEL_LERP;
				state_d     = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

@@ rtl/piecewise_linear_gain_curve_top.sv @@
`timescale 1ns / 1ps
// Top level of the piecewise-linear gain curve: channel ports, controller and datapath.
// Depends on plgc_pkg, the interfaces in plgc_ifs, plgc_ctrl and plgc_dp.
//
//   Channel  Direction  Transfer carries
//   req      in         req_type, point_index, point_x, point_y, position
//   rsp      out        gain (one per query, none per load)
//   cfg      in         point_count (always ready)
//
// A query with no points, or one resolved at the first or the last point, skips the scan
// and the divider; an interior query scans the segments one entry per cycle through the
// single memory read port and then runs the 17-step restoring divider. A request is taken
// only while the sequencer is idle.
// The output register holds a finished gain while rsp stalls, and the next request
// is taken meanwhile. arst_n clears the sequencer, point_count and output valid; the
// breakpoint memory is not cleared.
module piecewise_linear_gain_curve_top import plgc_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	plgc_req_if.sink   req,
	plgc_rsp_if.source rsp,
	plgc_cfg_if.sink   cfg
);

	dp_cmd_t                       cmd;
	dp_status_t                    status;
	logic [$clog2(MAX_POINTS)-1:0] rd_addr;

	assign cfg.ready = 1'b1;

	plgc_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg.valid),
		.cfg_count (cfg.point_count),
		.in_valid  (req.valid),
		.in_type   (req.req_type),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.status    (status),
		.cmd       (cmd),
		.rd_addr   (rd_addr)
	);

	plgc_dp #(
		.MAX_POINTS(MAX_POINTS)
	) u_dp (
		.clk         (clk),
		.cmd         (cmd),
		.rd_addr     (rd_addr),
		.point_index (req.point_index),
		.point_x     (req.point_x),
		.point_y     (req.point_y),
		.position    (req.position),
		.status      (status),
		.gain        (rsp.gain)
	);

	// A finished gain never overwrites one that has not been transferred.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!rsp.valid || rsp.ready))
		else $error("output register loaded while a result was pending");

	// The divider is never started on a zero-width segment.
	a_span_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_ld |-> !status.span_zero)
		else $error("division started with zero span");

	// A load never happens while a query is in flight.
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mem_wr |-> (req.valid && req.ready && !cmd.res_ld))
		else $error("breakpoint written outside an accepted load");

endmodule

@@ verif/tb_piecewise_linear_gain_curve_top.sv @@
`timescale 1ns / 1ps
// Testbench for piecewise_linear_gain_curve_top: breakpoint loads and gain queries checked
// against a gain curve predictor kept in the bench, under random sender gaps and response stalls.
// Depends on plgc_pkg, the channel interfaces in plgc_ifs and the RTL of the block.
module tb_piecewise_linear_gain_curve_top;
	import plgc_pkg::*;

	localparam int TABLE_DEPTH   = MAX_POINTS_DEF;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 60;
	localparam int ITEM_TARGET   = 1850;
	// The slowest run is about 1900 items, each with the block's own processing plus sender
	// gaps and response stalls; the limit leaves a wide margin on top of that.
	localparam int CYCLE_LIMIT   = 600000;

	typedef struct {
		logic             req_type;
		logic [IDX_W-1:0] point_index;
		val_t             point_x;
		val_t             point_y;
		val_t             position;
	} curve_req_t;

	logic clk;
	logic arst_n;

	plgc_req_if req_ch ();
	plgc_rsp_if rsp_ch ();
	plgc_cfg_if cfg_ch ();

	piecewise_linear_gain_curve_top #(.MAX_POINTS(TABLE_DEPTH)) i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// Shadow copy of the breakpoint table and the point count.
	val_t             curve_x [TABLE_DEPTH];
	val_t             curve_y [TABLE_DEPTH];
	logic [CNT_W-1:0] curve_count;
	val_t             gain_expected [$];

	int          mismatch_cnt;
	int          gains_checked;
	int          load_cnt;
	int          query_cnt;
	int          count_writes;
	int          item_cnt;
	int          burst_left;
	int unsigned cycle_cnt;
	bit          gaps_on;
	bit          stalls_on;
	logic [31:0] stall_pattern;
	int          stall_bit;

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_cnt++;
	endtask

	function automatic val_t clamp_unit(input val_t v);
		return (v > ONE_FX) ? ONE_FX : v;
	endfunction

	// Gain at a fade position for the current table and point count.
	function automatic val_t predict_gain(input val_t position_in);
		val_t            t_pos;
		int              n_pts;
		int              seg;
		longint unsigned ax;
		longint unsigned ay;
		longint unsigned bx;
		longint unsigned by;
		longint unsigned off;
		longint unsigned span;
		t_pos = clamp_unit(position_in);
		n_pts = (curve_count > TABLE_DEPTH) ? TABLE_DEPTH : int'(curve_count);
		if (n_pts == 0)
			return t_pos;
		if (t_pos <= curve_x[0])
			return curve_y[0];
		if (t_pos >= curve_x[n_pts-1])
			return curve_y[n_pts-1];
		// The first segment that brackets the position sets the gain.
		for (seg = 0; seg + 1 < n_pts; seg++) begin
			ax = curve_x[seg];
			ay = curve_y[seg];
			bx = curve_x[seg+1];
			by = curve_y[seg+1];
			if (t_pos >= ax && t_pos <= bx) begin
				span = bx - ax;
				off  = t_pos - ax;
				if (span == 0)
					return val_t'(by);
				// A falling segment truncates its step toward the first y.
				if (by >= ay)
					return val_t'(ay + (by - ay) * off / span);
				return val_t'(ay - (ay - by) * off / span);
			end
		end
		return curve_y[n_pts-1];
	endfunction

	// Drives one request, waits for its transfer and updates the predictor.
	// Starts and ends at a falling edge.
	task automatic send_req(input curve_req_t item);
		int gap;
		if (gaps_on && burst_left == 0) begin
			req_ch.valid <= 1'b0;
			gap = ($urandom_range(0, 9) == 0) ? $urandom_range(12, 24) : $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 12);
		end
		req_ch.valid       <= 1'b1;
		req_ch.req_type    <= item.req_type;
		req_ch.point_index <= item.point_index;
		req_ch.point_x     <= item.point_x;
		req_ch.point_y     <= item.point_y;
		req_ch.position    <= item.position;
		do @(posedge clk); while (!req_ch.ready);
		if (item.req_type == REQ_LOAD) begin
			if (item.point_index < TABLE_DEPTH) begin
				curve_x[item.point_index] = clamp_unit(item.point_x);
				curve_y[item.point_index] = clamp_unit(item.point_y);
			end
			load_cnt++;
		end else begin
			gain_expected.push_back(predict_gain(item.position));
			query_cnt++;
		end
		item_cnt++;
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
	endtask

	// The unused fields of each request carry random values.
	task automatic load_point(input int idx, input val_t x_val, input val_t y_val);
		curve_req_t item;
		item.req_type    = REQ_LOAD;
		item.point_index = idx[IDX_W-1:0];
		item.point_x     = x_val;
		item.point_y     = y_val;
		item.position    = val_t'($urandom());
		send_req(item);
	endtask

	task automatic query_gain(input val_t pos);
		curve_req_t item;
		item.req_type    = REQ_QUERY;
		item.point_index = IDX_W'($urandom());
		item.point_x     = val_t'($urandom());
		item.point_y     = val_t'($urandom());
		item.position    = pos;
		send_req(item);
	endtask

	// Waits until every gain has come back and any trailing load has finished.
	task automatic wait_idle();
		req_ch.valid <= 1'b0;
		while (gain_expected.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_point_count(input logic [CNT_W-1:0] value);
		wait_idle();
		cfg_ch.valid       <= 1'b1;
		cfg_ch.point_count <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		curve_count = value;
		count_writes++;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	function automatic val_t random_coord();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE_FX;
			2: return val_t'($urandom_range(65537, 131071));
			default: return val_t'($urandom_range(0, 65536));
		endcase
	endfunction

	// Positions cluster on and around breakpoints, with spread and out-of-range values.
	function automatic val_t random_position(input int used);
		int pick;
		pick = (used > 0) ? $urandom_range(0, used - 1) : 0;
		if (used == 0)
			return ($urandom_range(0, 1) == 0) ? val_t'($urandom()) : val_t'($urandom_range(0, 65536));
		case ($urandom_range(0, 9))
			0, 1: return curve_x[pick];
			2: return curve_x[pick] + 1'b1;
			3: return (curve_x[pick] == 0) ? '0 : curve_x[pick] - 1'b1;
			4: return val_t'($urandom());
			5: return ($urandom_range(0, 1) == 0) ? '0 : ONE_FX;
			default: return val_t'($urandom_range(0, 65536));
		endcase
	endfunction

	// Fills slots 0..used-1 so no query reads a slot that was never written.
	// Shapes: mostly ascending, some with repeated x, some unsorted.
	task automatic load_random_table(input int used, input int shape);
		int unsigned x_at;
		int          stride;
		int          idx;
		val_t        x_val;
		x_at   = $urandom_range(0, 8192);
		stride = (used > 0) ? 131072 / used : 65536;
		for (idx = 0; idx < used; idx++) begin
			if (shape >= 8) begin
				x_at = random_coord();
			end else if (idx > 0 && !(shape >= 6 && $urandom_range(0, 2) == 0)) begin
				x_at = x_at + $urandom_range(0, stride);
				if (x_at > ONE_FX)
					x_at = ONE_FX;
			end
			x_val = val_t'(x_at);
			// A last x above 1.0 saturates and keeps the table ascending.
			if (idx == used - 1 && $urandom_range(0, 3) == 0)
				x_val = val_t'($urandom_range(65537, 131071));
			load_point(idx, x_val, random_coord());
		end
		// A slot past the point count is written but stays out of the search.
		if (used < TABLE_DEPTH && $urandom_range(0, 1) == 0)
			load_point($urandom_range(used, TABLE_DEPTH - 1), random_coord(), random_coord());
	endtask

	// With no points the gain is the clamped position.
	task automatic test_linear_fallback();
		query_gain('0);
		query_gain(val_t'(65535));
		query_gain(ONE_FX);
		query_gain(val_t'(65537));
		query_gain(val_t'(131071));
	endtask

	// Four points: saturated y, a falling segment, a repeated x and a saturated last x.
	task automatic test_breakpoint_table();
		write_point_count(CNT_W'(4));
		load_point(0, val_t'(16384), val_t'(100000));
		load_point(1, val_t'(32768), val_t'(60000));
		load_point(2, val_t'(32768), val_t'(20000));
		load_point(3, val_t'(131071), val_t'(65535));
		query_gain('0);
		query_gain(val_t'(16384));
		query_gain(val_t'(20000));
		query_gain(val_t'(32768));
		query_gain(val_t'(40000));
		query_gain(ONE_FX);
		query_gain(val_t'(100000));
	endtask

	// A single point gives its y everywhere.
	task automatic test_single_point();
		write_point_count(CNT_W'(1));
		query_gain('0);
		query_gain(val_t'(50000));
		query_gain(val_t'(131071));
	endtask

	// Random tables and queries; the first phases cover full, above-table and tiny counts.
	task automatic test_random_curves();
		logic [CNT_W-1:0] count_plan [6];
		logic [CNT_W-1:0] count_now;
		int               phase;
		int               used;
		count_plan = '{16, 31, 17, 2, 1, 0};
		phase = 0;
		while (item_cnt < ITEM_TARGET) begin
			if (phase < 6)
				count_now = count_plan[phase];
			else if ($urandom_range(0, 3) == 0)
				count_now = CNT_W'($urandom_range(0, 31));
			else
				count_now = CNT_W'($urandom_range(2, 16));
			gaps_on   = ($urandom_range(0, 3) != 0);
			stalls_on = ($urandom_range(0, 3) != 0);
			write_point_count(count_now);
			used = (count_now > TABLE_DEPTH) ? TABLE_DEPTH : int'(count_now);
			load_random_table(used, $urandom_range(0, 9));
			repeat ($urandom_range(20, 40)) begin
				if ($urandom_range(0, 6) == 0)
					load_point($urandom_range(0, TABLE_DEPTH - 1), random_coord(), random_coord());
				else
					query_gain(random_position(used));
			end
			phase++;
		end
	endtask

	// Response side: ready follows a random stall pattern, or stays high.
	initial rsp_ch.ready = 1'b0;

	always @(negedge clk) begin
		if (!stalls_on) begin
			rsp_ch.ready <= 1'b1;
		end else begin
			if (stall_bit == 0)
				stall_pattern = ($urandom_range(0, 7) == 0) ? 32'hFFFF_0000 : $urandom();
			rsp_ch.ready <= stall_pattern[stall_bit];
			stall_bit = (stall_bit + 1) % 32;
		end
	end

	// Each gain transfer is checked against the oldest outstanding query.
	always @(posedge clk) begin
		val_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (gain_expected.size() == 0) begin
				report_mismatch($sformatf("gain %0d with no query outstanding", rsp_ch.gain));
			end else begin
				want = gain_expected.pop_front();
				gains_checked++;
				if (rsp_ch.gain !== want)
					report_mismatch($sformatf("gain %0d, predicted %0d", rsp_ch.gain, want));
			end
		end
	end

	// Run limit.
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("Run limit of %0d cycles reached, %0d gains outstanding",
			cycle_cnt, gain_expected.size());
		$display("Verification failed");
		$finish;
	end

	// Main sequence.
	initial begin
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.req_type    = REQ_LOAD;
		req_ch.point_index = '0;
		req_ch.point_x     = '0;
		req_ch.point_y     = '0;
		req_ch.position    = '0;
		cfg_ch.valid       = 1'b0;
		cfg_ch.point_count = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			curve_x[i] = '0;
			curve_y[i] = '0;
		end
		curve_count   = '0;
		mismatch_cnt  = 0;
		gains_checked = 0;
		load_cnt      = 0;
		query_cnt     = 0;
		count_writes  = 0;
		item_cnt      = 0;
		burst_left    = 0;
		stall_bit     = 0;
		stall_pattern = '1;
		gaps_on       = 1'b1;
		stalls_on     = 1'b1;

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_linear_fallback();
		test_breakpoint_table();
		test_single_point();
		test_random_curves();

		wait_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);

		$display("Covered %0d breakpoint loads and %0d gain queries over %0d point count writes.",
			load_cnt, query_cnt, count_writes);
		$display("Compared %0d gains, %0d mismatches.", gains_checked, mismatch_cnt);
		if (mismatch_cnt == 0 && gain_expected.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
